[rtl/sprite_layer_compositor_assert.svh]
// ----------------------------------------------------------------------------
// Sprite layer compositor assertion macros
// Concurrent assertion shorthands used by the compositor RTL, clocked on the
// rising edge and held off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SPRITE_LAYER_COMPOSITOR_ASSERT_SVH
`define SPRITE_LAYER_COMPOSITOR_ASSERT_SVH

// Same-cycle implication.
`define SLC_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define SLC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/slc_pkg.sv]
// ----------------------------------------------------------------------------
// Sprite layer compositor package
// Frame geometry, field codes and the shared multiplier result type.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int MAX_DIM     = 256;
  localparam int FRAME_WORDS = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(FRAME_WORDS);
  localparam int COORD_W     = $clog2(MAX_DIM);
  localparam int DIM_W       = 9;
  localparam int PROD_W      = 20;

  localparam logic [4:0] MODE_MULTIPLY = 5'd1;
  localparam logic       ACT_BLEND     = 1'b0;
  localparam logic       ACT_READ      = 1'b1;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod;  // plain product
    logic        [7:0]        rnd;   // rounded 8-bit product, low byte
  } slc_mul_res_t;

endpackage

[rtl/slc_mul_unit.sv]
// ----------------------------------------------------------------------------
// Sprite layer compositor shared multiplier
// Signed by unsigned product with the rounded 8-bit scaling step; used for
// the address, the multiply mode and every interpolation.
// ----------------------------------------------------------------------------
module slc_mul_unit (
  input  logic signed [9:0]      op_a,
  input  logic        [8:0]      op_b,
  output slc_pkg::slc_mul_res_t  res
);
  import slc_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   t;
  logic signed [PROD_W+1:0] sum;

  always_comb begin
    prod = PROD_W'(op_a * $signed({1'b0, op_b}));
    // t = a*b + 0x80, then ((t >> 8) + t) >> 8 with floor shifts
    t    = (PROD_W+1)'(prod) + (PROD_W+1)'(signed'(9'sh080));
    sum  = (PROD_W+2)'(t >>> 8) + (PROD_W+2)'(t);
    res.prod = prod;
    res.rnd  = sum[15:8];
  end

endmodule

[rtl/sprite_layer_compositor.sv]
// ----------------------------------------------------------------------------
// Sprite layer compositor
// RGBA frame store with normal and multiply blending, read-and-clear access.
// ----------------------------------------------------------------------------
// Usage: each input word on in_* is a blend or a read at a signed (x, y).
// Coordinates outside the frame, and blends on a hidden layer, change nothing
// and return a word with applied low and zero pixel. A read returns the stored
// pixel and clears it; a blend returns a zero pixel with applied high.
// One result word on out_* follows every input word, in order.
// Steps: address; read; multiply (multiply blends); alpha and colour (blends);
// write; result. A dropped word skips from address to result. in_tready rises
// together with out_tvalid, so a word is taken only once the last result is
// registered. All multiplications go through one shared multiplier, one step
// a cycle (address, three multiply products, alpha, three colours), and the
// frame memory has a single read and a single write port.
// At reset the frame size goes to 256 x 256 and a clearing pass writes zero
// to all 65536 pixels, one a cycle; in_tready stays low until the pass ends.
// cfg_* writes are taken at any time but are meant for idle periods.
// The result sits in an output register: a stalled receiver holds the word
// there, and the block takes the next input meanwhile, waiting only when a
// second result is ready before the first has gone.
// ----------------------------------------------------------------------------
`include "sprite_layer_compositor_assert.svh"

module sprite_layer_compositor (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // dest_x[15:0], dest_y[31:16], src_red[39:32], src_green[47:40],
  // src_blue[55:48], src_alpha[63:56], opacity[71:64], blend_mode[76:72]
  input  logic [79:0] in_tdata,
  // action[0], layer_visible[1]
  input  logic [1:0]  in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16], pixel_alpha[31:24]
  output logic [31:0] out_tdata,
  // applied[0]
  output logic [0:0]  out_tuser
);
  import slc_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ADDR, ST_READ, ST_MULT,
    ST_ALPHA, ST_COLOUR, ST_WRITE, ST_RESULT
  } state_t;

  state_t state_r;

  // configuration
  logic [DIM_W-1:0] width_r, height_r;
  logic [DIM_W-1:0] eff_w, eff_h;

  // item held for the duration of its work
  logic               act_r, vis_r;
  logic signed [15:0] x_r, y_r;
  logic [31:0]        src_r;
  logic [7:0]         op_r;
  logic [4:0]         mode_r;

  logic [ADDR_W-1:0] idx_r, clr_r;
  logic [1:0]        ch_r;
  logic [7:0]        alpha_r;
  logic [23:0]       col_r;
  logic [31:0]       rd_pix_r;
  logic              applied_r;
  logic              in_frame;

  // frame memory
  logic [31:0]       mem [FRAME_WORDS];
  logic [31:0]       mem_rdata_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;

  // shared multiplier
  logic signed [9:0] mul_a;
  logic [8:0]        mul_b;
  slc_mul_res_t      mul_res;

  // output register
  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;
  logic        out_tuser_r;

  logic [7:0] d_ch, s_ch, da, sa;
  logic       in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // oversized registers saturate to the frame limit
  assign eff_w = (width_r  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_r;
  assign eff_h = (height_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_r;

  assign in_frame = !x_r[15] && !y_r[15]
                 && (16'(x_r) < 16'(eff_w)) && (16'(y_r) < 16'(eff_h));

  assign d_ch = mem_rdata_r[{ch_r, 3'b000} +: 8];
  assign s_ch = src_r[{ch_r, 3'b000} +: 8];
  assign da   = mem_rdata_r[31:24];
  assign sa   = src_r[31:24];

  slc_mul_unit u_mul (
    .op_a (mul_a),
    .op_b (mul_b),
    .res  (mul_res)
  );

  // operand selection for the shared multiplier
  always_comb begin
    unique case (state_r)
      ST_ADDR: begin
        mul_a = 10'({2'b00, y_r[COORD_W-1:0]});
        mul_b = eff_w;
      end
      ST_MULT: begin
        mul_a = 10'({2'b00, d_ch});
        mul_b = {1'b0, s_ch};
      end
      ST_ALPHA: begin
        mul_a = 10'({2'b00, sa}) - 10'({2'b00, da});
        mul_b = {1'b0, op_r};
      end
      ST_COLOUR: begin
        mul_a = 10'({2'b00, s_ch}) - 10'({2'b00, d_ch});
        mul_b = {1'b0, op_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // memory port control
  always_comb begin
    mem_re    = (state_r == ST_READ);
    mem_we    = (state_r == ST_CLEAR) || (state_r == ST_WRITE);
    mem_waddr = (state_r == ST_CLEAR) ? clr_r : idx_r;
    // a read clears its pixel; a blend with zero alpha stores all zeros
    if (state_r == ST_CLEAR || act_r == ACT_READ || alpha_r == 8'd0) begin
      mem_wdata = '0;
    end else begin
      mem_wdata = {alpha_r, col_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[idx_r];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_DIM);
      height_r <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      ch_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // drop the result word once the receiver takes it; the result state
      // reloads the register itself
      if (out_tvalid_r && out_tready && state_r != ST_RESULT) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == ADDR_W'(FRAME_WORDS - 1)) begin
            state_r <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_acc) begin
            x_r     <= in_tdata[15:0];
            y_r     <= in_tdata[31:16];
            src_r   <= in_tdata[63:32];
            op_r    <= in_tdata[71:64];
            mode_r  <= in_tdata[76:72];
            act_r   <= in_tuser[0];
            vis_r   <= in_tuser[1];
            state_r <= ST_ADDR;
          end
        end

        ST_ADDR: begin
          // index = x + y * width
          idx_r     <= ADDR_W'(mul_res.prod) + ADDR_W'(x_r[COORD_W-1:0]);
          rd_pix_r  <= '0;
          ch_r      <= '0;
          applied_r <= in_frame && (act_r == ACT_READ || vis_r);
          if (in_frame && (act_r == ACT_READ || vis_r)) begin
            state_r <= ST_READ;
          end else begin
            state_r <= ST_RESULT;
          end
        end

        ST_READ: begin
          if (act_r == ACT_READ) begin
            state_r <= ST_WRITE;
          end else if (mode_r == MODE_MULTIPLY) begin
            state_r <= ST_MULT;
          end else begin
            state_r <= ST_ALPHA;
          end
        end

        ST_MULT: begin
          // replace the source colour by the product, keep source alpha
          src_r[{ch_r, 3'b000} +: 8] <= mul_res.rnd;
          if (ch_r == 2'd2) begin
            ch_r    <= '0;
            state_r <= ST_ALPHA;
          end else begin
            ch_r <= ch_r + 1'b1;
          end
        end

        ST_ALPHA: begin
          alpha_r <= da + mul_res.rnd;
          state_r <= ST_COLOUR;
        end

        ST_COLOUR: begin
          priority if (da == 8'd0) begin
            col_r[{ch_r, 3'b000} +: 8] <= s_ch;
          end else if (sa == 8'd0) begin
            col_r[{ch_r, 3'b000} +: 8] <= d_ch;
          end else begin
            col_r[{ch_r, 3'b000} +: 8] <= d_ch + mul_res.rnd;
          end
          if (ch_r == 2'd2) begin
            ch_r    <= '0;
            state_r <= ST_WRITE;
          end else begin
            ch_r <= ch_r + 1'b1;
          end
        end

        ST_WRITE: begin
          if (act_r == ACT_READ) begin
            rd_pix_r <= mem_rdata_r;
          end
          state_r <= ST_RESULT;
        end

        ST_RESULT: begin
          // hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= rd_pix_r;
            out_tuser_r  <= applied_r;
            state_r      <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `SLC_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, state_r == ST_CLEAR, !in_tready)
  `SLC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_acc, !in_tready)
  `SLC_ASSERT_NOW(a_result_from_seq, clk, rst_n, $rose(out_tvalid_r),
                  $past(state_r) == ST_RESULT)
  `SLC_ASSERT_NOW(a_write_only_when_due, clk, rst_n, mem_we,
                  state_r == ST_CLEAR || (state_r == ST_WRITE && applied_r))

endmodule
